FILE: hdl/ils_pkg.sv
// ils_pkg: shared types and constants of the indexed LIFO stack unit.
// Depends on nothing; used by ils_stack_ram and indexed_lifo_stack_unit.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   localparam int STACK_DEPTH = 8;

   localparam int WORD_W = 32;
   localparam int POS_W  = 11;
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(STACK_DEPTH);

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_REPLACE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_UNAVAIL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

FILE: hdl/indexed_lifo_stack_unit.sv
// indexed_lifo_stack_unit: LIFO stack with push, pop, peek and replace by position.
// Depends on ils_pkg and ils_stack_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                   Transfer when
// req       in         req_cmd, req_value, req_position        req_valid && req_ready
// rsp       out        rsp_data, rsp_status, rsp_fill          rsp_valid && rsp_ready
//
// Push, replace and every failing command: the result is loaded into the
// output register at the accepting edge; a new request is taken while rsp_ready is high.
// Pop and successful peek: the stack RAM read is registered, so the result
// is loaded in S_READ and no new request is taken before that.
// Reset clears the fill count, the FSM and rsp_valid; RAM contents stay undefined.
// A waiting result blocks a new transfer only when rsp_ready is low.

module indexed_lifo_stack_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [1:0]                 req_cmd,
   input  wire  signed [31:0]         req_value,
   input  wire  [10:0]                req_position,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [31:0]         rsp_data,
   output logic [1:0]                 rsp_status,
   output logic [10:0]                rsp_fill
);
   import ils_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_fill_ff, rsp_fill_in;

   ram_req_type       ram_req;
   logic [WORD_W-1:0] rd_data;

   logic              req_xfer;
   logic              rsp_free;
   cmd_type           cmd;
   logic [POS_W-1:0]  fill_ext;
   logic [POS_W-1:0]  slot_full;
   logic              pos_ok;
   logic [FILL_W-1:0] fill_dec;

   ils_stack_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Output register may take a new result when empty or being drained now.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign req_xfer  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   // Position p maps to slot fill - p; valid for 1 <= p <= fill.
   assign fill_ext  = POS_W'(fill_ff);
   assign slot_full = fill_ext - req_position;
   assign pos_ok    = (req_position != '0) && (req_position <= fill_ext);
   assign fill_dec  = fill_ff - FILL_W'(1);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = fill_ff[ADDR_W-1:0];
      ram_req.wr_data = req_value;
      ram_req.rd_addr = slot_full[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               rsp_data_in   = '0;
               rsp_status_in = ST_OK;
               rsp_valid_in  = 1'b1;
               case (cmd)
                  CMD_PUSH: begin
                     if (fill_ff == FILL_MAX) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        ram_req.wr_en = 1'b1;
                        fill_in       = fill_ff + FILL_W'(1);
                     end
                  end
                  CMD_POP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = ST_UNAVAIL;
                     end else begin
                        ram_req.rd_addr = fill_dec[ADDR_W-1:0];
                        fill_in         = fill_dec;
                        rsp_valid_in    = 1'b0;
                        state_in        = S_READ;
                     end
                  end
                  CMD_PEEK: begin
                     if (!pos_ok) begin
                        rsp_status_in = ST_UNAVAIL;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  CMD_REPLACE: begin
                     if (!pos_ok) begin
                        rsp_status_in = ST_UNAVAIL;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = slot_full[ADDR_W-1:0];
                     end
                  end
                  default: begin
                     rsp_status_in = ST_UNAVAIL;
                  end
               endcase
               rsp_fill_in = POS_W'(fill_in);
            end
         end
         S_READ: begin
            // RAM word arrives in the cycle after the address; a write on the
            // previous edge is already in the array, so no bypass is needed.
            rsp_data_in  = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_fill   = rsp_fill_ff;

   // Fill never runs past the stack depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond stack depth");

   // A shown result always reports the current fill count.
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fill_ff == POS_W'(fill_ff)))
      else $error("result fill disagrees with fill count");

   // A push onto a non-full stack grows it by one.
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (cmd == CMD_PUSH) && (fill_ff != FILL_MAX))
      |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("push did not grow the stack");

   // The read cycle always ends with a result on the output.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("read cycle did not deliver a result");

endmodule

`default_nettype wire

FILE: hdl/ils_stack_ram.sv
// ils_stack_ram: word store of the stack, one write and one registered read.
// Depends on ils_pkg for sizes and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module ils_stack_ram (
   input  wire                      clock,
   input  ils_pkg::ram_req_type     ram_req,
   output logic [ils_pkg::WORD_W-1:0] rd_data
);
   import ils_pkg::*;

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data <= mem[ram_req.rd_addr];
   end

endmodule

`default_nettype wire
